>>> hdl/ldh_pkg.sv
// Shared widths, codes and types for the lattice deposit and hop block.
`default_nettype none

package ldh_pkg;

  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned COORD_W   = 5;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_THR   = 5;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_DEPOSIT = 2'd0,
    FUNC_HOP     = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_Y_DEC = 2'd0,
    DIR_X_INC = 2'd1,
    DIR_Y_INC = 2'd2,
    DIR_X_DEC = 2'd3
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_ZERO  = 3'd0,
    REG_THR_ONE   = 3'd1,
    REG_THR_TWO   = 3'd2,
    REG_THR_THREE = 3'd3,
    REG_THR_FOUR  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [HEIGHT_W-1:0] site_height;
    logic [CNT_W-1:0]    neighbour_count;
    logic                hopped;
    logic [HEIGHT_W-1:0] target_height;
    logic                ignored;
    logic                saturated;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/ldh_ifs.sv
// Channel interfaces: item input, result output and configuration write.
`default_nettype none

interface ldh_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [ldh_pkg::COORD_W-1:0]   site_x;
  logic [ldh_pkg::COORD_W-1:0]   site_y;
  logic [ldh_pkg::FRAC_W-1:0]    random_fraction;
  logic [ldh_pkg::DIR_W-1:0]     direction;

  modport source (output valid, func, site_x, site_y, random_fraction, direction,
                  input ready);
  modport sink   (input valid, func, site_x, site_y, random_fraction, direction,
                  output ready);
endinterface

interface ldh_out_if;
  logic                          valid;
  logic                          ready;
  logic [ldh_pkg::HEIGHT_W-1:0]  site_height;
  logic [ldh_pkg::CNT_W-1:0]     neighbour_count;
  logic                          hopped;
  logic [ldh_pkg::HEIGHT_W-1:0]  target_height;
  logic                          ignored;
  logic                          saturated;

  modport source (output valid, site_height, neighbour_count, hopped, target_height,
                  ignored, saturated, input ready);
  modport sink   (input valid, site_height, neighbour_count, hopped, target_height,
                  ignored, saturated, output ready);
endinterface

interface ldh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ldh_pkg::CFG_IDX_W-1:0]   index;
  logic [ldh_pkg::HEIGHT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/lattice_deposit_and_hop.sv
// Top level: height grid in one synchronous RAM, driven by a read-modify-write sequencer.
//
// channel   dir  handshake     payload
// in_if     in   valid/ready   func, site_x, site_y, random_fraction, direction
// out_if    out  valid/ready   site_height, neighbour_count, hopped, target_height,
//                              ignored, saturated
// cfg_if    in   valid/ready   index (threshold register), data
//
// One item at a time through the single RAM port: a used, on-grid item reads its site, and
// for an interior hop its four neighbours, then writes back whatever changed. After reset
// a clearing pass writes zero to all GRID_SIDE*GRID_SIDE entries, one per cycle; no item
// is accepted until it ends.
// A held result does not block acceptance; the sequencer stalls in its last state only
// when a new result is ready while the previous one is still untaken.
`default_nettype none

module lattice_deposit_and_hop #(
  parameter int unsigned GRID_SIDE = 32
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  ldh_in_if.sink    in_if,
  ldh_out_if.source out_if,
  ldh_cfg_if.sink   cfg_if
);

  localparam int unsigned DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned HW    = ldh_pkg::HEIGHT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WR_SITE,
    S_WR_TGT,
    S_DONE
  } state_e;

  state_e state_q;

  // request latched at accept
  logic [1:0]                   func_q;
  logic [ldh_pkg::COORD_W-1:0]  x_q, y_q;
  logic [ldh_pkg::FRAC_W-1:0]   r_q;
  logic [ldh_pkg::DIR_W-1:0]    dir_q;

  logic [2:0]    step_q;
  logic [AW-1:0] clr_q;
  logic [HW-1:0] hgt_q [5];   // site, then neighbours y-1, x+1, y+1, x-1
  logic [HW-1:0] thr_q [ldh_pkg::NUM_THR];

  ldh_pkg::res_t res_q, res_d;
  ldh_pkg::res_t out_q;
  logic          out_valid_q;
  logic          wr_site_d;
  logic          wr_tgt_q, wr_tgt_d;
  logic [HW-1:0] site_new_q, site_new_d;
  logic [HW-1:0] tgt_new_q, tgt_new_d;

  // RAM
  logic [HW-1:0] mem [DEPTH];
  logic [HW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [HW-1:0] mem_wdata;

  // ---------------------------------------------------------------- address math
  logic          off_grid, interior;
  logic [AW-1:0] site_addr, tgt_addr;
  logic [AW-1:0] nb_addr [4];
  logic [2:0]    last_step;

  always_comb begin
    off_grid = (32'(x_q) >= GRID_SIDE) || (32'(y_q) >= GRID_SIDE);
    interior = (x_q != '0) && (y_q != '0) &&
               (32'(x_q) + 32'd2 <= GRID_SIDE) && (32'(y_q) + 32'd2 <= GRID_SIDE);
    site_addr = AW'(32'(x_q) * GRID_SIDE + 32'(y_q));
    nb_addr[ldh_pkg::DIR_Y_DEC] = site_addr - AW'(1);
    nb_addr[ldh_pkg::DIR_X_INC] = site_addr + AW'(GRID_SIDE);
    nb_addr[ldh_pkg::DIR_Y_INC] = site_addr + AW'(1);
    nb_addr[ldh_pkg::DIR_X_DEC] = site_addr - AW'(GRID_SIDE);
    tgt_addr = nb_addr[dir_q];
    if (func_q == ldh_pkg::FUNC_NONE || off_grid) begin
      last_step = 3'd0;
    end else if (func_q == ldh_pkg::FUNC_HOP && interior) begin
      last_step = 3'd5;
    end else begin
      last_step = 3'd1;
    end
  end

  // ---------------------------------------------------------------- evaluation
  logic [ldh_pkg::CNT_W-1:0] n_cnt;
  logic [HW-1:0]             tgt_h;
  logic                      pass;

  always_comb begin
    n_cnt = ldh_pkg::CNT_W'(hgt_q[1] != '0) + ldh_pkg::CNT_W'(hgt_q[2] != '0) +
            ldh_pkg::CNT_W'(hgt_q[3] != '0) + ldh_pkg::CNT_W'(hgt_q[4] != '0);
    tgt_h = hgt_q[3'(dir_q) + 3'd1];
    pass  = r_q < thr_q[n_cnt];

    res_d      = '0;
    wr_site_d  = 1'b0;
    wr_tgt_d   = 1'b0;
    site_new_d = hgt_q[0];
    tgt_new_d  = tgt_h;

    if (func_q == ldh_pkg::FUNC_NONE) begin
      res_d = '0;
    end else if (off_grid) begin
      res_d.ignored = 1'b1;
    end else if (func_q == ldh_pkg::FUNC_DEPOSIT) begin
      if (hgt_q[0] == ldh_pkg::HEIGHT_MAX) begin
        res_d.saturated   = 1'b1;
        res_d.site_height = hgt_q[0];
      end else begin
        site_new_d        = hgt_q[0] + HW'(1);
        wr_site_d         = 1'b1;
        res_d.site_height = site_new_d;
      end
    end else if (func_q == ldh_pkg::FUNC_READ) begin
      res_d.site_height = hgt_q[0];
    end else if (!interior || hgt_q[0] == '0) begin
      res_d.ignored     = 1'b1;
      res_d.site_height = hgt_q[0];
    end else begin
      res_d.neighbour_count = n_cnt;
      res_d.site_height     = hgt_q[0];
      res_d.target_height   = tgt_h;
      if (pass) begin
        if (tgt_h == ldh_pkg::HEIGHT_MAX) begin
          res_d.saturated = 1'b1;
        end else begin
          site_new_d          = hgt_q[0] - HW'(1);
          tgt_new_d           = tgt_h + HW'(1);
          wr_site_d           = 1'b1;
          wr_tgt_d            = 1'b1;
          res_d.hopped        = 1'b1;
          res_d.site_height   = site_new_d;
          res_d.target_height = tgt_new_d;
        end
      end
    end
  end

  // ---------------------------------------------------------------- RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = site_addr;
    mem_wdata = site_new_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
      end
      S_READ: begin
        mem_re = step_q < last_step;
        if (step_q != 3'd0) begin
          mem_addr = nb_addr[2'(step_q - 3'd1)];
        end
      end
      S_WR_SITE: begin
        mem_we = 1'b1;
      end
      S_WR_TGT: begin
        mem_we    = 1'b1;
        mem_addr  = tgt_addr;
        mem_wdata = tgt_new_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------- configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ldh_pkg::NUM_THR; i++) begin
        thr_q[i] <= '0;
      end
    end else if (cfg_if.valid && cfg_if.index <= ldh_pkg::REG_THR_FOUR) begin
      thr_q[cfg_if.index] <= cfg_if.data;
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic out_load;

  assign in_if.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      func_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      r_q         <= '0;
      dir_q       <= '0;
      res_q       <= '0;
      wr_tgt_q    <= 1'b0;
      site_new_q  <= '0;
      tgt_new_q   <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        hgt_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_if.valid) begin
            func_q  <= in_if.func;
            x_q     <= in_if.site_x;
            y_q     <= in_if.site_y;
            r_q     <= in_if.random_fraction;
            dir_q   <= in_if.direction;
            step_q  <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          // read issued at step s returns at step s+1
          if (step_q != 3'd0) begin
            hgt_q[step_q - 3'd1] <= rdata_q;
          end
          if (step_q == last_step) begin
            state_q <= S_EVAL;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_EVAL: begin
          res_q      <= res_d;
          wr_tgt_q   <= wr_tgt_d;
          site_new_q <= site_new_d;
          tgt_new_q  <= tgt_new_d;
          state_q    <= wr_site_d ? S_WR_SITE : S_DONE;
        end
        S_WR_SITE: begin
          state_q <= wr_tgt_q ? S_WR_TGT : S_DONE;
        end
        S_WR_TGT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.site_height     = out_q.site_height;
  assign out_if.neighbour_count = out_q.neighbour_count;
  assign out_if.hopped          = out_q.hopped;
  assign out_if.target_height   = out_q.target_height;
  assign out_if.ignored         = out_q.ignored;
  assign out_if.saturated       = out_q.saturated;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for lattice_deposit_and_hop against a height-grid predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned GRID_SIDE = 32;

  typedef struct packed {
    ldh_pkg::func_e                func;
    logic [ldh_pkg::COORD_W-1:0]   site_x;
    logic [ldh_pkg::COORD_W-1:0]   site_y;
    logic [ldh_pkg::FRAC_W-1:0]    random_fraction;
    ldh_pkg::dir_e                 direction;
  } lattice_item_t;

  logic clk_i;
  logic rst_ni;

  ldh_in_if  item_ch ();
  ldh_out_if result_ch ();
  ldh_cfg_if cfg_ch ();

  lattice_deposit_and_hop #(
    .GRID_SIDE (GRID_SIDE)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (item_ch),
    .out_if (result_ch),
    .cfg_if (cfg_ch)
  );

  // predicted grid, thresholds and results in flight
  logic [ldh_pkg::HEIGHT_W-1:0] lattice_heights [GRID_SIDE*GRID_SIDE];
  logic [ldh_pkg::HEIGHT_W-1:0] hop_threshold [ldh_pkg::NUM_THR];
  ldh_pkg::res_t                pending_results [$];
  int unsigned                  mismatch_count;
  bit                           pause_enabled;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic ldh_pkg::res_t predict_lattice_step(input lattice_item_t it);
    ldh_pkg::res_t res;
    int unsigned   x;
    int unsigned   y;
    int unsigned   here;
    int unsigned   dest;
    int unsigned   occupied;
    res = '0;
    x = it.site_x;
    y = it.site_y;
    if (it.func == ldh_pkg::FUNC_NONE) return res;
    if (x >= GRID_SIDE || y >= GRID_SIDE) begin
      res.ignored = 1'b1;
      return res;
    end
    here = x * GRID_SIDE + y;
    case (it.func)
      ldh_pkg::FUNC_DEPOSIT: begin
        if (lattice_heights[here] == ldh_pkg::HEIGHT_MAX) res.saturated = 1'b1;
        else lattice_heights[here] = lattice_heights[here] + 1'b1;
        res.site_height = lattice_heights[here];
      end
      ldh_pkg::FUNC_READ: begin
        res.site_height = lattice_heights[here];
      end
      default: begin
        if (x < 1 || y < 1 || x + 2 > GRID_SIDE || y + 2 > GRID_SIDE ||
            lattice_heights[here] == '0) begin
          res.ignored     = 1'b1;
          res.site_height = lattice_heights[here];
        end else begin
          occupied = int'(lattice_heights[here - 1] != '0) +
                     int'(lattice_heights[here + GRID_SIDE] != '0) +
                     int'(lattice_heights[here + 1] != '0) +
                     int'(lattice_heights[here - GRID_SIDE] != '0);
          case (it.direction)
            ldh_pkg::DIR_Y_DEC: dest = here - 1;
            ldh_pkg::DIR_X_INC: dest = here + GRID_SIDE;
            ldh_pkg::DIR_Y_INC: dest = here + 1;
            default:            dest = here - GRID_SIDE;
          endcase
          if (it.random_fraction < hop_threshold[occupied]) begin
            // a full destination column blocks the move
            if (lattice_heights[dest] == ldh_pkg::HEIGHT_MAX) begin
              res.saturated = 1'b1;
            end else begin
              lattice_heights[dest] = lattice_heights[dest] + 1'b1;
              lattice_heights[here] = lattice_heights[here] - 1'b1;
              res.hopped = 1'b1;
            end
          end
          res.neighbour_count = ldh_pkg::CNT_W'(occupied);
          res.site_height     = lattice_heights[here];
          res.target_height   = lattice_heights[dest];
        end
      end
    endcase
    return res;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin
    ldh_pkg::res_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with no transaction pending, site_height", '0,
                      32'(result_ch.site_height));
      end else begin
        want = pending_results.pop_front();
        if (result_ch.site_height !== want.site_height)
          note_mismatch("site_height", 32'(want.site_height),
                        32'(result_ch.site_height));
        if (result_ch.neighbour_count !== want.neighbour_count)
          note_mismatch("neighbour_count", 32'(want.neighbour_count),
                        32'(result_ch.neighbour_count));
        if (result_ch.hopped !== want.hopped)
          note_mismatch("hopped", 32'(want.hopped), 32'(result_ch.hopped));
        if (result_ch.target_height !== want.target_height)
          note_mismatch("target_height", 32'(want.target_height),
                        32'(result_ch.target_height));
        if (result_ch.ignored !== want.ignored)
          note_mismatch("ignored", 32'(want.ignored), 32'(result_ch.ignored));
        if (result_ch.saturated !== want.saturated)
          note_mismatch("saturated", 32'(want.saturated), 32'(result_ch.saturated));
      end
    end
  end

  // result side back-pressure, one draw per transaction
  initial begin
    int unsigned stall;
    result_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = pause_enabled ? $urandom_range(15, 0) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  // valid stays high on return; drain_results, or a pause in the next call, lowers it
  task automatic send_item(input ldh_pkg::func_e f, input logic [ldh_pkg::COORD_W-1:0] x,
                           input logic [ldh_pkg::COORD_W-1:0] y,
                           input logic [ldh_pkg::FRAC_W-1:0] r,
                           input ldh_pkg::dir_e d);
    int unsigned   gap;
    lattice_item_t it;
    gap = pause_enabled ? $urandom_range(15, 0) : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it = '{func: f, site_x: x, site_y: y, random_fraction: r, direction: d};
    item_ch.valid           <= 1'b1;
    item_ch.func            <= f;
    item_ch.site_x          <= x;
    item_ch.site_y          <= y;
    item_ch.random_fraction <= r;
    item_ch.direction       <= d;
    do @(posedge clk_i); while (!item_ch.ready);
    pending_results.push_back(predict_lattice_step(it));
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // valid stays high on return; caller lowers it after the last write
  task automatic cfg_write(input logic [ldh_pkg::CFG_IDX_W-1:0] index,
                           input logic [ldh_pkg::HEIGHT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (index < ldh_pkg::NUM_THR) hop_threshold[index] = value;
  endtask

  task automatic set_thresholds(input logic [ldh_pkg::HEIGHT_W-1:0] t0,
                                input logic [ldh_pkg::HEIGHT_W-1:0] t1,
                                input logic [ldh_pkg::HEIGHT_W-1:0] t2,
                                input logic [ldh_pkg::HEIGHT_W-1:0] t3,
                                input logic [ldh_pkg::HEIGHT_W-1:0] t4);
    cfg_write(ldh_pkg::REG_THR_ZERO, t0);
    cfg_write(ldh_pkg::REG_THR_ONE, t1);
    cfg_write(ldh_pkg::REG_THR_TWO, t2);
    cfg_write(ldh_pkg::REG_THR_THREE, t3);
    cfg_write(ldh_pkg::REG_THR_FOUR, t4);
  endtask

  function automatic logic [ldh_pkg::FRAC_W-1:0] rand_frac();
    return ldh_pkg::FRAC_W'($urandom_range(16'hFFFF, 0));
  endfunction

  function automatic ldh_pkg::dir_e rand_dir();
    return ldh_pkg::dir_e'($urandom_range(3, 0));
  endfunction

  // thresholds for the directed cases, then writes to unused indexes that must not land
  task automatic test_register_writes();
    set_thresholds(16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001, 16'h0000);
    for (int k = ldh_pkg::NUM_THR; k < 2 ** ldh_pkg::CFG_IDX_W; k++)
      cfg_write(ldh_pkg::CFG_IDX_W'(k), 16'hFFFF);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_item(ldh_pkg::FUNC_READ, 0, 0, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_READ, 31, 31, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_DEPOSIT, 0, 0, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_DEPOSIT, 31, 31, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_DEPOSIT, 31, 0, rand_frac(), rand_dir());
    // occupied but on the edge, then empty interior
    send_item(ldh_pkg::FUNC_HOP, 0, 0, 16'h0000, ldh_pkg::DIR_X_INC);
    send_item(ldh_pkg::FUNC_HOP, 31, 31, 16'h0000, ldh_pkg::DIR_Y_DEC);
    send_item(ldh_pkg::FUNC_HOP, 5, 5, 16'h0000, ldh_pkg::DIR_Y_INC);
    send_item(ldh_pkg::FUNC_NONE, 17, 3, 16'hFFFF, ldh_pkg::DIR_X_DEC);
    send_item(ldh_pkg::FUNC_DEPOSIT, 10, 10, rand_frac(), rand_dir());
    // compare is strict: full-scale threshold rejects full-scale fraction
    send_item(ldh_pkg::FUNC_HOP, 10, 10, 16'hFFFF, ldh_pkg::DIR_Y_DEC);
    send_item(ldh_pkg::FUNC_HOP, 10, 10, 16'hFFFE, ldh_pkg::DIR_Y_DEC);
    send_item(ldh_pkg::FUNC_DEPOSIT, 10, 10, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_DEPOSIT, 10, 10, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_DEPOSIT, 11, 10, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_HOP, 10, 10, 16'h7FFF, ldh_pkg::DIR_Y_INC);
    send_item(ldh_pkg::FUNC_HOP, 10, 10, 16'h8000, ldh_pkg::DIR_X_DEC);
    send_item(ldh_pkg::FUNC_HOP, 10, 10, 16'h0000, ldh_pkg::DIR_X_DEC);
    send_item(ldh_pkg::FUNC_DEPOSIT, 10, 10, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_HOP, 10, 10, 16'h0000, ldh_pkg::DIR_X_INC);
    send_item(ldh_pkg::FUNC_DEPOSIT, 1, 1, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_HOP, 1, 1, 16'h0000, ldh_pkg::DIR_Y_DEC);
    send_item(ldh_pkg::FUNC_DEPOSIT, 30, 30, rand_frac(), rand_dir());
    send_item(ldh_pkg::FUNC_HOP, 30, 30, 16'h0000, ldh_pkg::DIR_X_INC);
    send_item(ldh_pkg::FUNC_READ, 31, 30, rand_frac(), rand_dir());
    drain_results();
  endtask

  // mostly inside a 7x7 window so columns pile up and neighbour counts vary
  task automatic send_random_item(input int unsigned ox, input int unsigned oy);
    int unsigned                 sel;
    ldh_pkg::func_e              f;
    logic [ldh_pkg::COORD_W-1:0] x;
    logic [ldh_pkg::COORD_W-1:0] y;
    logic [ldh_pkg::FRAC_W-1:0]  r;
    sel = $urandom_range(99, 0);
    if (sel < 35)      f = ldh_pkg::FUNC_DEPOSIT;
    else if (sel < 80) f = ldh_pkg::FUNC_HOP;
    else if (sel < 95) f = ldh_pkg::FUNC_READ;
    else               f = ldh_pkg::FUNC_NONE;
    if ($urandom_range(9, 0) < 8) begin
      x = ldh_pkg::COORD_W'(ox + $urandom_range(6, 0));
      y = ldh_pkg::COORD_W'(oy + $urandom_range(6, 0));
    end else begin
      x = ldh_pkg::COORD_W'($urandom_range(31, 0));
      y = ldh_pkg::COORD_W'($urandom_range(31, 0));
    end
    if ($urandom_range(7, 0) == 0) r = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
    else r = rand_frac();
    send_item(f, x, y, r, rand_dir());
  endtask

  task automatic test_random_phases();
    int unsigned ox;
    int unsigned oy;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_thresholds(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_thresholds(16'hFFFF, 16'hC000, 16'h8000, 16'h4000, 16'h0000);
        5: set_thresholds(16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF);
        default: set_thresholds(rand_frac(), rand_frac(), rand_frac(), rand_frac(), rand_frac());
      endcase
      cfg_ch.valid <= 1'b0;
      pause_enabled = (p != 3);
      ox = 1 + (p % 4) * 7;
      oy = (p < 4) ? 1 : 16;
      repeat (270) send_random_item(ox, oy);
      drain_results();
    end
    pause_enabled = 1'b1;
  endtask

  initial begin
    foreach (lattice_heights[i]) lattice_heights[i] = '0;
    foreach (hop_threshold[i]) hop_threshold[i] = '0;
    mismatch_count = 0;
    pause_enabled  = 1'b1;
    rst_ni                  <= 1'b0;
    item_ch.valid           <= 1'b0;
    item_ch.func            <= ldh_pkg::FUNC_DEPOSIT;
    item_ch.site_x          <= '0;
    item_ch.site_y          <= '0;
    item_ch.random_fraction <= '0;
    item_ch.direction       <= ldh_pkg::DIR_Y_DEC;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= ldh_pkg::REG_THR_ZERO;
    cfg_ch.data             <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_register_writes();
    test_directed_cases();
    test_random_phases();

    drain_results();
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, several times the slowest correct run including the clearing pass
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> lattice_deposit_and_hop.f
hdl/ldh_pkg.sv
hdl/ldh_ifs.sv
hdl/lattice_deposit_and_hop.sv
sim/tb_top.sv
